// ===== sv/bfa_pkg.sv =====
// Shared widths and codes for the bitmap frame allocator.
// No dependencies; compile first.
`default_nettype none

package bfa_pkg;

   localparam int OP_W     = 2;
   localparam int FRAME_W  = 15;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 16;

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOMEM  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_DOUBLE = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd3;

endpackage

`default_nettype wire

// ===== sv/bfa_if.sv =====
// Valid/ready channel interfaces: request, response and CSR write.
// Depends on bfa_pkg for field widths.
`default_nettype none

interface bfa_req_if
   import bfa_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [FRAME_W-1:0] frame;

   modport source (output valid, operation, frame, input ready);
   modport sink   (input valid, operation, frame, output ready);
endinterface

interface bfa_rsp_if
   import bfa_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [FRAME_W-1:0]  frame_out;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  free_count;

   modport source (output valid, frame_out, status, free_count, input ready);
   modport sink   (input valid, frame_out, status, free_count, output ready);
endinterface

interface bfa_csr_if
   import bfa_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] frame_count;

   modport source (output valid, frame_count, input ready);
   modport sink   (input valid, frame_count, output ready);
endinterface

`default_nettype wire

// ===== sv/bitmap_frame_allocator_unit.sv =====
// Bitmap frame allocator top level: bitmap RAM, next-fit scan, free/reserve.
// Depends on bfa_pkg and the channel interfaces in bfa_if.sv.
//
//   channel   dir  beat contents                          accepted when
//   req_chan  in   operation, frame                       valid & ready
//   rsp_chan  out  frame_out, status, free_count          valid & ready
//   csr_chan  in   frame_count                            valid & ready
//
// Sequence: free, reserve and error beats do a RAM read, then a check
// and write back. Allocate reads the start word, then the next-fit scan
// visits words, up to frame_count/WORD_BITS of them; the bitmap RAM read
// (one word per cycle) paces the scan.
// Reset: a clearing pass writes zero to all MAX_FRAMES/WORD_BITS RAM words,
// one per cycle; req_chan.ready stays low until it finishes.
// Stalls: a held response does not block acceptance; the write-back waits
// until the response register is free.
// WORD_BITS must be a power of two.
`default_nettype none

module bitmap_frame_allocator_unit
   import bfa_pkg::*;
#(
   parameter int MAX_FRAMES = 32768,
   parameter int WORD_BITS  = 32
) (
   input  wire            clock,
   input  wire            reset,
   bfa_req_if.sink        req_chan,
   bfa_rsp_if.source      rsp_chan,
   bfa_csr_if.sink        csr_chan
);

   localparam int MAP_WORDS = MAX_FRAMES / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int WCNT_W    = $clog2(MAP_WORDS + 1);
   localparam int WB_LOG    = $clog2(WORD_BITS);
   localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
   localparam int EFF_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_CHK   = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [WB_LOG-1:0]    bit_ff, bit_in;
   logic [AW-1:0]        w_ff, w_in;
   logic [WCNT_W-1:0]    n_ff, n_in;
   logic                 pre_done_ff, pre_done_in;
   logic [STATUS_W-1:0]  pre_status_ff, pre_status_in;
   logic [AW-1:0]        start_ff, start_in;
   logic [CNT_W-1:0]     free_ff, free_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [COUNT_W-1:0]   csr_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]   rsp_frame_ff, rsp_frame_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // bitmap RAM, set bit = frame free
   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic                 wr_en;

   logic [EFF_W-1:0]     fc_ext, eff, frame_ext, free_ext;
   logic [WCNT_W-1:0]    words;
   logic [AW-1:0]        start_eff, frame_word, w_next;
   logic                 req_fire, in_range;
   logic [WORD_BITS-1:0] bit_mask;
   logic                 hit, was_free, done, commit, out_free;
   logic [WB_LOG-1:0]    low_bit;
   logic [EFF_W-1:0]     alloc_frame;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.frame_out  = rsp_frame_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.free_count = rsp_count_ff;

   // frame_count clamps at MAX_FRAMES; only whole words are searched
   assign fc_ext    = EFF_W'(csr_ff);
   assign eff       = (fc_ext > EFF_W'(MAX_FRAMES)) ? EFF_W'(MAX_FRAMES) : fc_ext;
   assign words     = WCNT_W'(eff >> WB_LOG);
   assign start_eff = (WCNT_W'(start_ff) >= words) ? '0 : start_ff;
   assign frame_ext = EFF_W'(req_chan.frame);
   assign in_range  = frame_ext < eff;
   assign frame_word = AW'(frame_ext >> WB_LOG);
   assign w_next    = (WCNT_W'(w_ff) + WCNT_W'(1) == words) ? '0 : w_ff + AW'(1);

   assign bit_mask    = WORD_BITS'(1) << bit_ff;
   assign was_free    = |(rd_data_ff & bit_mask);
   assign hit         = |rd_data_ff;
   assign alloc_frame = (EFF_W'(w_ff) << WB_LOG) | EFF_W'(low_bit);
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign free_ext    = EFF_W'(free_in);

   // lowest set bit of the word under test
   always_comb begin
      low_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (rd_data_ff[i]) begin
            low_bit = WB_LOG'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      bit_in        = bit_ff;
      w_in          = w_ff;
      n_in          = n_ff;
      pre_done_in   = pre_done_ff;
      pre_status_in = pre_status_ff;
      start_in      = start_ff;
      free_in       = free_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_frame_in  = rsp_frame_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rd_addr       = w_ff;
      wr_addr       = w_ff;
      wr_data       = rd_data_ff;
      wr_en         = 1'b0;
      done          = 1'b0;
      commit        = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            rd_addr = (req_chan.operation == OP_ALLOC) ? start_eff : frame_word;
            if (req_fire) begin
               state_in = ST_CHK;
               op_in    = req_chan.operation;
               bit_in   = WB_LOG'(req_chan.frame);
               w_in     = rd_addr;
               n_in     = '0;
               case (req_chan.operation) inside
                  OP_ALLOC: begin
                     pre_done_in   = (words == '0);
                     pre_status_in = STAT_NOMEM;
                  end
                  OP_FREE, OP_RESERVE: begin
                     pre_done_in   = !in_range;
                     pre_status_in = STAT_RANGE;
                  end
                  default: begin
                     pre_done_in   = 1'b1;
                     pre_status_in = STAT_OK;
                  end
               endcase
            end
         end

         ST_CHK: begin
            rsp_frame_in  = rsp_frame_ff;
            rsp_status_in = rsp_status_ff;
            done          = 1'b1;
            if (pre_done_ff) begin
               rsp_status_in = pre_status_ff;
               rsp_frame_in  = '0;
            end else begin
               rsp_status_in = STAT_OK;
               rsp_frame_in  = '0;
               case (op_ff) inside
                  OP_ALLOC: begin
                     if (hit) begin
                        wr_en        = 1'b1;
                        wr_data      = rd_data_ff & ~(WORD_BITS'(1) << low_bit);
                        start_in     = w_ff;
                        rsp_frame_in = FRAME_W'(alloc_frame);
                        if (free_ff != '0) begin
                           free_in = free_ff - CNT_W'(1);
                        end
                     end else if (n_ff + WCNT_W'(1) == words) begin
                        rsp_status_in = STAT_NOMEM;
                     end else begin
                        // empty word: move on, next read issues now
                        done    = 1'b0;
                        w_in    = w_next;
                        n_in    = n_ff + WCNT_W'(1);
                        rd_addr = w_next;
                     end
                  end
                  OP_FREE: begin
                     if (was_free) begin
                        rsp_status_in = STAT_DOUBLE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = rd_data_ff | bit_mask;
                        free_in = free_ff + CNT_W'(1);
                     end
                  end
                  OP_RESERVE: begin
                     if (was_free) begin
                        wr_en   = 1'b1;
                        wr_data = rd_data_ff & ~bit_mask;
                        if (free_ff != '0) begin
                           free_in = free_ff - CNT_W'(1);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end

            commit = done && out_free;
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_count_in = (free_ext > EFF_W'(16'hFFFF)) ? 16'hFFFF
                                                             : COUNT_W'(free_ext);
            end else begin
               // hold everything while the response register is busy
               wr_en         = 1'b0;
               free_in       = free_ff;
               start_in      = start_ff;
               rsp_frame_in  = rsp_frame_ff;
               rsp_status_in = rsp_status_ff;
               rsp_count_in  = rsp_count_ff;
            end
         end

         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         start_ff     <= '0;
         free_ff      <= '0;
         csr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         start_ff     <= start_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            csr_ff <= csr_chan.frame_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      bit_ff        <= bit_in;
      w_ff          <= w_in;
      n_ff          <= n_in;
      pre_done_ff   <= pre_done_in;
      pre_status_ff <= pre_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // no response can appear before the clearing pass is over
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("response during bitmap clear");

   // the free count moves only on a committed operation
   a_count_commit: assert property (@(posedge clock) disable iff (reset)
      (free_ff != $past(free_ff)) |-> $past(commit))
      else $error("free count changed without commit");

   // the scan never visits more words than are searched
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK && op_ff == OP_ALLOC && !pre_done_ff) |-> (n_ff < words))
      else $error("allocation scan overran");

   // a commit always leaves a response waiting
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("commit lost its response");

endmodule

`default_nettype wire

// ===== sim/bfa_checker.sv =====
// Scoreboard for the bitmap frame allocator: watches the request, response and CSR channels,
// predicts each response from its own bitmap copy and compares. Depends on bfa_pkg and bfa_if.sv.
`default_nettype none

module bfa_checker
   import bfa_pkg::*;
(
   input  wire  clock,
   input  wire  reset,
   bfa_req_if   req_chan,
   bfa_rsp_if   rsp_chan,
   bfa_csr_if   csr_chan,
   output int   fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FRAMES = 32768;
   localparam int WORD_BITS  = 32;
   localparam int MAP_WORDS  = MAX_FRAMES / WORD_BITS;

   typedef struct packed {
      logic [FRAME_W-1:0]  frame_out;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  free_count;
   } frame_grant_type;

   bit [WORD_BITS-1:0] free_words [MAP_WORDS];
   int unsigned        resume_word;
   int unsigned        free_total;
   bit [COUNT_W-1:0]   frame_limit;
   frame_grant_type    grants_due [$];
   int                 mismatches;

   // Applies one request beat to the shadow bitmap and returns the response it must produce.
   function automatic frame_grant_type grant_for(logic [OP_W-1:0] op,
                                                 logic [FRAME_W-1:0] frame);
      frame_grant_type g;
      int unsigned     managed;
      int unsigned     words;
      int unsigned     w;
      int unsigned     b;
      g = '0;
      managed = (frame_limit > MAX_FRAMES) ? MAX_FRAMES : frame_limit;
      case (op) inside
         OP_ALLOC: begin
            words = managed / WORD_BITS;
            g.status = STAT_NOMEM;
            w = (resume_word >= words) ? 0 : resume_word;
            for (int n = 0; n < words; n++) begin
               if (free_words[w] != '0) begin
                  for (b = 0; b < WORD_BITS - 1 && !free_words[w][b]; b++) ;
                  free_words[w][b] = 1'b0;
                  resume_word = w;
                  if (free_total > 0) free_total--;
                  g.frame_out = FRAME_W'(w * WORD_BITS + b);
                  g.status = STAT_OK;
                  break;
               end
               w = (w + 1 >= words) ? 0 : w + 1;
            end
         end
         OP_FREE, OP_RESERVE: begin
            if (frame >= managed) begin
               g.status = STAT_RANGE;
            end else begin
               w = frame / WORD_BITS;
               b = frame % WORD_BITS;
               if (op == OP_FREE) begin
                  if (free_words[w][b]) begin
                     g.status = STAT_DOUBLE;
                  end else begin
                     free_words[w][b] = 1'b1;
                     free_total++;
                  end
               end else if (free_words[w][b]) begin
                  free_words[w][b] = 1'b0;
                  if (free_total > 0) free_total--;
               end
            end
         end
         default: ;
      endcase
      g.free_count = (free_total > 32'hFFFF) ? 16'hFFFF : free_total[COUNT_W-1:0];
      return g;
   endfunction

   always @(posedge clock) begin
      frame_grant_type want;
      frame_grant_type got;
      if (reset) begin
         foreach (free_words[i]) free_words[i] = '0;
         resume_word = 0;
         free_total  = 0;
         frame_limit = '0;
         grants_due.delete();
         mismatches  = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.frame_out, rsp_chan.status, rsp_chan.free_count};
            if (grants_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response beat with none pending: frame %0d status %0d count %0d",
                           $realtime, got.frame_out, got.status, got.free_count);
            end else begin
               want = grants_due.pop_front();
               if (got.frame_out !== want.frame_out || got.status !== want.status ||
                   got.free_count !== want.free_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: response mismatch: expected frame %0d status %0d count %0d,",
                               " got frame %0d status %0d count %0d"}, $realtime,
                              want.frame_out, want.status, want.free_count,
                              got.frame_out, got.status, got.free_count);
               end
            end
         end
         if (csr_chan.valid && csr_chan.ready)
            frame_limit = csr_chan.frame_count;
         if (req_chan.valid && req_chan.ready)
            grants_due.push_back(grant_for(req_chan.operation, req_chan.frame));
      end
      fail_count = mismatches + grants_due.size();
   end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Top of the frame allocator testbench: clock, reset, stimulus and verdict.
// Depends on bfa_pkg, bfa_if.sv, the allocator RTL and sim/bfa_checker.sv.
`default_nettype none

module testbench
   import bfa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Operation code 3 has no name in the package; the block must ignore it.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Idle modes for a phase.
   localparam int IDLE_NONE = 0;
   localparam int IDLE_SEND = 1;
   localparam int IDLE_RECV = 2;
   localparam int IDLE_BOTH = 3;

   // Well above the slowest honest run (a clearing pass over 1024 RAM words, full scans of
   // 1024 words on the max-size phases, 87% stalls elsewhere).
   localparam int unsigned CYCLE_LIMIT = 1_500_000;

   logic        clock = 1'b0;
   logic        reset;
   int          send_idle_pct;
   int          rsp_stall_pct;
   int          rsp_hold;
   int unsigned req_beats;
   int unsigned rsp_beats;
   int unsigned cycle_count;
   int          fail_count;

   bfa_req_if req_chan ();
   bfa_rsp_if rsp_chan ();
   bfa_csr_if csr_chan ();

   bitmap_frame_allocator_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   bfa_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_chan   (csr_chan),
      .fail_count (fail_count)
   );

   always #1 clock = ~clock;

   // Beat counters: the stimulus uses them to know when the block has drained.
   always @(posedge clock) begin
      if (reset) begin
         req_beats = 0;
         rsp_beats = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) req_beats++;
         if (rsp_chan.valid && rsp_chan.ready) rsp_beats++;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // Response side. A nonzero rsp_hold keeps ready low for that many cycles, counted here,
   // regardless of what the sender is doing; otherwise ready drops at the phase's stall rate.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_chan.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_chan.ready = ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Offers one request beat and returns at the rising edge that accepts it. Valid stays
   // high afterward; the next call either replaces the payload or drops valid for a gap.
   task automatic push_req(logic [OP_W-1:0] op, logic [FRAME_W-1:0] frame);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.operation = op;
      req_chan.frame     = frame;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Sender stands down until every response for the beats sent so far is back.
   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      wait (rsp_beats == req_beats);
   endtask

   // The frame count is only changed while the block is idle. Every request yields a
   // response, so after draining a short pause is plenty.
   task automatic write_frame_count(logic [COUNT_W-1:0] value);
      drain();
      repeat (4) @(negedge clock);
      csr_chan.valid       = 1'b1;
      csr_chan.frame_count = value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   // One random phase at a given frame count. Mostly in-range allocate/free/reserve so the
   // bitmap fills and empties, plus out-of-range frames and the odd ignored opcode.
   task automatic run_phase(logic [COUNT_W-1:0] frames, int items, int mode, int hold);
      int unsigned        managed;
      int                 roll;
      logic [OP_W-1:0]    op;
      logic [FRAME_W-1:0] frame;
      write_frame_count(frames);
      send_idle_pct = (mode == IDLE_SEND) ? 87 : (mode == IDLE_BOTH) ? 18 : 0;
      rsp_stall_pct = (mode == IDLE_RECV) ? 87 : (mode == IDLE_BOTH) ? 18 : 0;
      rsp_hold = hold;
      managed = (frames > 32768) ? 32768 : frames;
      repeat (items) begin
         roll  = $urandom_range(0, 99);
         frame = FRAME_W'($urandom);
         if (roll < 38) begin
            op = OP_ALLOC;
         end else if (roll < 88) begin
            op = (roll < 76) ? OP_FREE : OP_RESERVE;
            if (managed > 0) frame = FRAME_W'($urandom_range(0, managed - 1));
         end else if (roll < 96) begin
            op = roll[0] ? OP_FREE : OP_RESERVE;
            if (managed <= 32767) frame = FRAME_W'($urandom_range(managed, 32767));
         end else begin
            op = OP_UNUSED;
         end
         push_req(op, frame);
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.operation   = OP_ALLOC;
      req_chan.frame       = '0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.frame_count = '0;
      send_idle_pct        = 0;
      rsp_stall_pct        = 0;
      rsp_hold             = 0;
      cycle_count          = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, no idling. Frame count is still zero from reset: nothing to search,
      // everything out of range.
      push_req(OP_ALLOC, 15'd0);
      push_req(OP_FREE, 15'd0);
      push_req(OP_RESERVE, 15'h7FFF);

      // All-ones count behaves as the maximum.
      write_frame_count(16'hFFFF);
      push_req(OP_FREE, 15'h7FFF);
      push_req(OP_FREE, 15'd0);
      push_req(OP_FREE, 15'd0);          // double free
      push_req(OP_RESERVE, 15'd5);       // reserve of a reserved frame
      push_req(OP_ALLOC, 15'h7FFF);      // takes frame 0
      push_req(OP_ALLOC, 15'd0);         // long scan to the last word
      push_req(OP_ALLOC, 15'd0);         // full scan, nothing free
      push_req(OP_FREE, 15'h5555);
      push_req(OP_FREE, 15'h2AAA);
      push_req(OP_RESERVE, 15'h5555);
      push_req(OP_UNUSED, 15'h7FFF);

      // Shrink: remembered word now beyond the searched range; 40 frames leave a partial word.
      write_frame_count(16'd40);
      push_req(OP_FREE, 15'd35);
      push_req(OP_ALLOC, 15'd0);         // partial word is never searched
      push_req(OP_FREE, 15'd3);
      push_req(OP_ALLOC, 15'd0);
      push_req(OP_FREE, 15'd40);         // exactly at the frame count
      push_req(OP_RESERVE, 15'd35);

      write_frame_count(16'h8000);
      push_req(OP_ALLOC, 15'd0);
      push_req(OP_RESERVE, 15'd100);

      // Fewer frames than one word: allocate has nothing to scan.
      write_frame_count(16'd31);
      push_req(OP_ALLOC, 15'd0);
      push_req(OP_FREE, 15'd30);
      push_req(OP_FREE, 15'd31);

      // Random phases. Each starts after a full drain; the third begins with a long
      // receiver hold-off so the block backs up and stalls its request side.
      run_phase(16'd64,    200, IDLE_NONE, 0);
      run_phase(16'd100,   200, IDLE_SEND, 0);
      run_phase(16'd33,    150, IDLE_RECV, 400);
      run_phase(16'd255,   200, IDLE_BOTH, 0);
      run_phase(16'd1000,  150, IDLE_NONE, 0);
      run_phase(16'd32,    120, IDLE_RECV, 0);
      run_phase(16'h8000,   60, IDLE_BOTH, 0);
      run_phase(16'd513,   200, IDLE_SEND, 0);
      run_phase(16'd0,      30, IDLE_NONE, 0);
      run_phase(16'hFFFF,   40, IDLE_RECV, 0);
      run_phase(16'd160,   180, IDLE_BOTH, 0);

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/bfa_pkg.sv
sv/bfa_if.sv
sv/bitmap_frame_allocator_unit.sv
sim/bfa_checker.sv
sim/testbench.sv
